>>> design/skvt_pkg.sv
// Package for the sorted key/value table: sizes, operation and status codes,
// and the command struct broadcast to the cell chain. No dependencies.
package skvt_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned PldW     = 32;
  localparam int unsigned PosW     = 6;
  localparam int unsigned EcntW    = 7;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_SEARCH = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DUP      = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Broadcast to every cell.
  typedef struct packed {
    logic                   shift_in;
    logic                   shift_out;
    logic signed [KeyW-1:0] key;
    logic [PldW-1:0]        payload;
  } cell_cmd_t;

endpackage

>>> design/skvt_if.sv
// Valid/ready channel interfaces for the sorted key/value table.
// Depends on skvt_pkg for field widths.
interface skvt_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     func;
  logic signed [skvt_pkg::KeyW-1:0] key;
  logic [skvt_pkg::PldW-1:0]      payload;

  modport source (output valid, func, key, payload, input ready);
  modport sink   (input valid, func, key, payload, output ready);
endinterface

interface skvt_out_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 status;
  logic [skvt_pkg::PosW-1:0]  position;
  logic [skvt_pkg::PldW-1:0]  found_payload;
  logic [skvt_pkg::EcntW-1:0] entry_count;

  modport source (output valid, status, position, found_payload, entry_count, input ready);
  modport sink   (input valid, status, position, found_payload, entry_count, output ready);
endinterface

>>> design/skvt_cell.sv
// One cell of the sorted chain: holds a key and its payload, compares with
// the broadcast key and shifts toward either neighbor. Depends on skvt_pkg.
module skvt_cell (
  input  logic                             clk_i,
  input  skvt_pkg::cell_cmd_t              cmd_i,
  input  logic                             occupied_i,
  input  logic                             left_lt_i,
  input  logic signed [skvt_pkg::KeyW-1:0] left_key_i,
  input  logic [skvt_pkg::PldW-1:0]        left_payload_i,
  input  logic signed [skvt_pkg::KeyW-1:0] right_key_i,
  input  logic [skvt_pkg::PldW-1:0]        right_payload_i,
  output logic signed [skvt_pkg::KeyW-1:0] key_o,
  output logic [skvt_pkg::PldW-1:0]        payload_o,
  output logic                             lt_o,
  output logic                             hit_o
);
  import skvt_pkg::*;

  logic signed [KeyW-1:0] key_q;
  logic [PldW-1:0]        payload_q;

  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign lt_o      = occupied_i && (key_q < cmd_i.key);
  assign hit_o     = occupied_i && (key_q == cmd_i.key);

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_in && !lt_o) begin
      if (left_lt_i) begin
        key_q     <= cmd_i.key;
        payload_q <= cmd_i.payload;
      end else begin
        key_q     <= left_key_i;
        payload_q <= left_payload_i;
      end
    end else if (cmd_i.shift_out && !lt_o) begin
      key_q     <= right_key_i;
      payload_q <= right_payload_i;
    end
  end

endmodule

>>> design/sorted_key_value_table.sv
// Top level of the sorted key/value table: command register, chain of
// skvt_cell instances, entry counter and result register.
// Depends on skvt_pkg, skvt_if.sv and skvt_cell.sv.
//
// Usage:
//   in_i  (sink):   func (0 insert, 1 delete, 2 search, 3 no-op), key, payload.
//   out_o (source): status, position, found_payload, entry_count; one result
//                   transaction per input transaction, in order.
//   An accepted transaction is held in the command register until the result
//   register can take it; then every cell compares its key with the command
//   key in parallel and the chain shifts by one cell on insert or delete as
//   the result register loads. Each result is registered in the result
//   register. Throughput: one transaction per cycle while out_o is drained;
//   64 cells, constant time regardless of fill level.
//   Backpressure: the result register holds while out_o.ready is low; one
//   further transaction is accepted into the command register and waits.
//   Reset clears the entry count and the valid flags; no clearing pass, so
//   the table is usable on the first cycle after reset.
module sorted_key_value_table (
  input  logic clk_i,
  input  logic rst_ni,
  skvt_in_if.sink    in_i,
  skvt_out_if.source out_o
);
  import skvt_pkg::*;

  logic                   cmd_valid_q;
  func_e                  cmd_func_q;
  logic signed [KeyW-1:0] cmd_key_q;
  logic [PldW-1:0]        cmd_payload_q;
  logic [CntW-1:0]        count_q, count_d;

  logic                   out_valid_q;
  status_e                out_status_q, status_d;
  logic [PosW-1:0]        out_pos_q, pos_d;
  logic [PldW-1:0]        out_found_q, found_d;
  logic [EcntW-1:0]       out_cnt_q;

  logic                   fire;
  cell_cmd_t              cmd;
  logic [CAPACITY-1:0]    occ, lt, hit;
  logic signed [KeyW-1:0] cell_key [CAPACITY];
  logic [PldW-1:0]        cell_pld [CAPACITY];
  logic                   hit_any, full;
  logic [IdxW-1:0]        hit_idx;
  logic [PldW-1:0]        hit_pld;

  assign fire       = cmd_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !cmd_valid_q || fire;
  assign hit_any    = |hit;
  assign full       = (count_q == CntW'(CAPACITY));

  assign cmd.key       = cmd_key_q;
  assign cmd.payload   = cmd_payload_q;
  assign cmd.shift_in  = fire && (cmd_func_q == FUNC_INSERT) && !hit_any && !full;
  assign cmd.shift_out = fire && (cmd_func_q == FUNC_DELETE) && hit_any;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                   l_lt;
    logic signed [KeyW-1:0] l_key, r_key;
    logic [PldW-1:0]        l_pld, r_pld;

    assign occ[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_first
      assign l_lt  = 1'b1;
      assign l_key = '0;
      assign l_pld = '0;
    end else begin : g_mid
      assign l_lt  = lt[i-1];
      assign l_key = cell_key[i-1];
      assign l_pld = cell_pld[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign r_key = cell_key[i];
      assign r_pld = cell_pld[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_pld = cell_pld[i+1];
    end

    skvt_cell u_cell (
      .clk_i           (clk_i),
      .cmd_i           (cmd),
      .occupied_i      (occ[i]),
      .left_lt_i       (l_lt),
      .left_key_i      (l_key),
      .left_payload_i  (l_pld),
      .right_key_i     (r_key),
      .right_payload_i (r_pld),
      .key_o           (cell_key[i]),
      .payload_o       (cell_pld[i]),
      .lt_o            (lt[i]),
      .hit_o           (hit[i])
    );
  end

  // Keys are unique, so at most one hit; OR-encode it.
  always_comb begin
    hit_idx = '0;
    hit_pld = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        hit_idx = hit_idx | IdxW'(i);
        hit_pld = hit_pld | cell_pld[i];
      end
    end
  end

  always_comb begin
    status_d = ST_OK;
    pos_d    = '0;
    found_d  = '0;
    count_d  = count_q;
    unique case (cmd_func_q)
      FUNC_INSERT: begin
        if (hit_any) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      FUNC_DELETE: begin
        if (hit_any) begin
          count_d = count_q - CntW'(1);
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      FUNC_SEARCH: begin
        if (hit_any) begin
          pos_d   = PosW'(hit_idx);
          found_d = hit_pld;
        end else begin
          status_d = ST_NOTFOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        cmd_valid_q <= 1'b1;
      end else if (fire) begin
        cmd_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      cmd_func_q    <= func_e'(in_i.func);
      cmd_key_q     <= in_i.key;
      cmd_payload_q <= in_i.payload;
    end
    if (fire) begin
      out_status_q <= status_d;
      out_pos_q    <= pos_d;
      out_found_q  <= found_d;
      out_cnt_q    <= EcntW'(count_d);
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.position      = out_pos_q;
  assign out_o.found_payload = out_found_q;
  assign out_o.entry_count   = out_cnt_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_q |-> $onehot0(hit))
    else $error("more than one cell matches the key");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift_in |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not advance entry count");

  a_delete_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift_out |=> count_q == $past(count_q) - CntW'(1))
    else $error("delete did not reduce entry count");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_key_value_table: directed table, then
// fill/drain random traffic with idling and a long output hold-off.
// Depends on skvt_pkg, skvt_if.sv and the design sources.
module tb_top;
  import skvt_pkg::*;

  localparam int N_PER_PHASE = 230;
  localparam int N_DIRECTED  = 24;
  localparam int HOLD_AT     = 540;
  localparam int HOLD_LEN    = 150;
  localparam int WDOG_LIMIT  = 3000;

  typedef struct packed {
    status_e          status;
    logic [PosW-1:0]  position;
    logic [PldW-1:0]  found_payload;
    logic [EcntW-1:0] entry_count;
  } result_t;

  typedef struct packed {
    func_e           op;
    logic [KeyW-1:0] key;
    logic [PldW-1:0] pld;
    logic            typed;
    result_t         res;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic rdy_q  = 1'b0;

  skvt_in_if  in_if ();
  skvt_out_if out_if ();

  assign out_if.ready = rdy_q;

  sorted_key_value_table u_top (
    .clk_i,
    .rst_ni,
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #10 clk_i = ~clk_i;

  logic signed [KeyW-1:0] mirror_keys[$];
  logic [PldW-1:0]        mirror_plds[$];
  result_t                pending_results[$];
  dir_row_t               dir_rows[N_DIRECTED];

  int src_idle_pct = 36;
  int snk_idle_pct = 56;
  int n_errors     = 0;
  int results_seen = 0;
  int hold_cnt     = 0;
  bit held_off     = 1'b0;
  int idle_cycles  = 0;

  function automatic result_t dict_apply(func_e op, logic signed [KeyW-1:0] k,
                                         logic [PldW-1:0] pld);
    result_t r;
    int      idx;
    bit      hit;
    r   = '0;
    idx = 0;
    while (idx < mirror_keys.size() && mirror_keys[idx] < k) idx++;
    hit = (idx < mirror_keys.size()) && (mirror_keys[idx] == k);
    case (op)
      FUNC_INSERT: begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (mirror_keys.size() >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          mirror_keys.insert(idx, k);
          mirror_plds.insert(idx, pld);
        end
      end
      FUNC_DELETE: begin
        if (!hit) begin
          r.status = ST_NOTFOUND;
        end else begin
          mirror_keys.delete(idx);
          mirror_plds.delete(idx);
        end
      end
      FUNC_SEARCH: begin
        if (!hit) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.position      = idx[PosW-1:0];
          r.found_payload = mirror_plds[idx];
        end
      end
      default: ;
    endcase
    r.entry_count = EcntW'(mirror_keys.size());
    return r;
  endfunction

  function automatic logic [KeyW-1:0] pick_key(bit want_hit);
    logic [3:0] nib;
    if (want_hit && mirror_keys.size() > 0)
      return mirror_keys[$urandom_range(mirror_keys.size() - 1)];
    nib = $urandom_range(15);
    case ($urandom_range(3))
      0: return {{28{nib[3]}}, nib};
      1: begin
        case (nib[2:0])
          3'd0: return 32'h8000_0000;
          3'd1: return 32'h7FFF_FFFF;
          3'd2: return 32'h8000_0001;
          3'd3: return 32'h7FFF_FFFE;
          3'd4: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input func_e op, input logic [KeyW-1:0] key,
                          input logic [PldW-1:0] pld, input bit typed,
                          input result_t typed_res);
    result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.func    <= op;
    in_if.key     <= key;
    in_if.payload <= pld;
    do @(posedge clk_i); while (!in_if.ready);
    res = dict_apply(op, key, pld);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  // result side: check, then decide ready for the next cycle
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni) begin
      if (out_if.valid && rdy_q) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result transaction with nothing expected");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_if.status);
            n_errors++;
          end
          if (out_if.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_if.position);
            n_errors++;
          end
          if (out_if.found_payload !== want.found_payload) begin
            $error("found_payload: expected %h, got %h", want.found_payload,
                   out_if.found_payload);
            n_errors++;
          end
          if (out_if.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_if.entry_count);
            n_errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy_q <= 1'b0;
      end else if (!held_off && results_seen >= HOLD_AT) begin
        held_off = 1'b1;
        hold_cnt = HOLD_LEN;
        rdy_q <= 1'b0;
      end else begin
        rdy_q <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    func_e           op;
    logic [KeyW-1:0] k;
    int              roll;
    bit              filling;
    int              full_extra;

    in_if.valid   = 1'b0;
    in_if.func    = FUNC_NOP;
    in_if.key     = '0;
    in_if.payload = '0;
    filling       = 1'b1;
    full_extra    = 0;

    dir_rows = '{
      '{FUNC_SEARCH, 32'h0000_0000, 32'h0, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd0}},
      '{FUNC_DELETE, 32'h0000_0005, 32'h0, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd0}},
      '{FUNC_NOP,    32'h0000_0007, 32'h1, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd0}},
      '{FUNC_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd1}},
      '{FUNC_INSERT, 32'h8000_0000, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd2}},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd3}},
      '{FUNC_INSERT, 32'h0000_0000, 32'h5A5A_5A5A, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd4}},
      '{FUNC_SEARCH, 32'h8000_0000, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd4}},
      '{FUNC_SEARCH, 32'h7FFF_FFFF, 32'h0, 1'b1, '{ST_OK, 6'd3, 32'hFFFF_FFFF, 7'd4}},
      '{FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, 1'b1, '{ST_OK, 6'd1, 32'hA5A5_A5A5, 7'd4}},
      '{FUNC_SEARCH, 32'h0000_0000, 32'h0, 1'b1, '{ST_OK, 6'd2, 32'h5A5A_5A5A, 7'd4}},
      '{FUNC_INSERT, 32'hFFFF_FFFF, 32'h1234, 1'b1, '{ST_DUP, 6'd0, 32'h0, 7'd4}},
      '{FUNC_SEARCH, 32'h0000_0001, 32'h0, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd4}},
      '{FUNC_DELETE, 32'h0000_0001, 32'h0, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd4}},
      '{FUNC_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd4}},
      '{FUNC_DELETE, 32'h8000_0000, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd3}},
      '{FUNC_SEARCH, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
      '{FUNC_DELETE, 32'h7FFF_FFFF, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd2}},
      '{FUNC_INSERT, 32'h4000_0000, 32'h8000_0001, 1'b0, '0},
      '{FUNC_SEARCH, 32'h4000_0000, 32'h0, 1'b0, '0},
      '{FUNC_DELETE, 32'hFFFF_FFFF, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd2}},
      '{FUNC_DELETE, 32'h0000_0000, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd1}},
      '{FUNC_DELETE, 32'h4000_0000, 32'h0, 1'b1, '{ST_OK, 6'd0, 32'h0, 7'd0}},
      '{FUNC_SEARCH, 32'h4000_0000, 32'h0, 1'b1, '{ST_NOTFOUND, 6'd0, 32'h0, 7'd0}}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].key, dir_rows[i].pld, dir_rows[i].typed,
               dir_rows[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 36 : (ph == 1) ? 56 : 0;
      snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 36 : 0;
      for (int n = 0; n < N_PER_PHASE; n++) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          op = func_e'($urandom_range(3));
          k  = pick_key($urandom_range(1) == 1);
        end else if (filling) begin
          op = (roll < 78) ? FUNC_INSERT : (roll < 88) ? FUNC_SEARCH :
               (roll < 94) ? FUNC_DELETE : FUNC_NOP;
          if (op == FUNC_INSERT)
            k = pick_key($urandom_range(99) <
                         ((mirror_keys.size() == CAPACITY) ? 40 : 10));
          else
            k = pick_key($urandom_range(99) < 80);
        end else begin
          op = (roll < 75) ? FUNC_DELETE : (roll < 90) ? FUNC_SEARCH : FUNC_INSERT;
          k  = pick_key($urandom_range(99) < 85);
        end
        send_cmd(op, k, $urandom, 1'b0, '0);
        if (filling && mirror_keys.size() == CAPACITY) begin
          full_extra++;
          if (full_extra >= 6) begin
            filling    = 1'b0;
            full_extra = 0;
          end
        end else if (!filling && mirror_keys.size() == 0) begin
          filling = 1'b1;
        end
      end
    end

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
